// File: rtl/motion_inactivity_detector_defines.svh
// assertion macros for the motion inactivity detector
`ifndef MOTION_INACTIVITY_DETECTOR_DEFINES_SVH
`define MOTION_INACTIVITY_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define MID_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define MID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MID_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MID_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/mid_pkg.sv
`default_nettype none

package mid_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int AXES                = 9;
   localparam int SENSORS             = 3;
   localparam int AXES_PER_SENSOR     = 3;

   localparam int EPS_W   = 18;
   localparam int LIMIT_W = 8;
   localparam int COUNT_W = 8;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = EPS_W;

   localparam logic [EPS_W-1:0]   EPS_RESET   = EPS_W'(10);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STILL_EPSILON = 1'b0,
      CSR_STILL_LIMIT   = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_FORWARD = 2'd1,
      EV_SLEEP   = 2'd2,
      EV_WAKE    = 2'd3
   } event_type;

   typedef enum logic {
      ST_SLEEP  = 1'b0,
      ST_ACTIVE = 1'b1
   } state_type;

   // decision for the word leaving the input register
   typedef struct packed {
      event_type ev;
      logic      store;
   } decision_type;

   // controller state seen by the top level
   typedef struct packed {
      state_type          state;
      logic [COUNT_W-1:0] still_count;
   } ctrl_status_type;

endpackage

`default_nettype wire

// File: rtl/mid_if.sv
`default_nettype none

interface mid_req_if #(
   parameter int SAMPLE_BITS = mid_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic                          data_ready;
   logic                          motion_wake;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;
   logic signed [SAMPLE_BITS-1:0] gyro_x;
   logic signed [SAMPLE_BITS-1:0] gyro_y;
   logic signed [SAMPLE_BITS-1:0] gyro_z;
   logic signed [SAMPLE_BITS-1:0] mag_x;
   logic signed [SAMPLE_BITS-1:0] mag_y;
   logic signed [SAMPLE_BITS-1:0] mag_z;

   modport source (
      output valid, data_ready, motion_wake,
      output accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z,
      input  ready
   );
   modport sink (
      input  valid, data_ready, motion_wake,
      input  accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z,
      output ready
   );
endinterface

interface mid_rsp_if #(
   parameter int SAMPLE_BITS = mid_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    event_res;
   logic signed [SAMPLE_BITS-1:0] out_accel_x;
   logic signed [SAMPLE_BITS-1:0] out_accel_y;
   logic signed [SAMPLE_BITS-1:0] out_accel_z;
   logic signed [SAMPLE_BITS-1:0] out_gyro_x;
   logic signed [SAMPLE_BITS-1:0] out_gyro_y;
   logic signed [SAMPLE_BITS-1:0] out_gyro_z;
   logic signed [SAMPLE_BITS-1:0] out_mag_x;
   logic signed [SAMPLE_BITS-1:0] out_mag_y;
   logic signed [SAMPLE_BITS-1:0] out_mag_z;

   modport source (
      output valid, event_res,
      output out_accel_x, out_accel_y, out_accel_z, out_gyro_x, out_gyro_y, out_gyro_z,
      output out_mag_x, out_mag_y, out_mag_z,
      input  ready
   );
   modport sink (
      input  valid, event_res,
      input  out_accel_x, out_accel_y, out_accel_z, out_gyro_x, out_gyro_y, out_gyro_z,
      input  out_mag_x, out_mag_y, out_mag_z,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/motion_inactivity_detector.sv
// motion inactivity detector: sleep/active tracker for a nine-axis sample stream
// path: a word passes the input reg, then the result reg, before it is offered as a response
// throughput: one word per cycle unless rsp stalls; state updates as a word enters the result reg
// reset: synchronous active high; block sleeps, still count and stored sample are zero,
// epsilon returns to 10 and limit to 50; no clearing pass, words are taken right away
`default_nettype none
`include "motion_inactivity_detector_defines.svh"

module motion_inactivity_detector #(
   parameter int SAMPLE_BITS = mid_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   mid_req_if.sink                                req_ch,
   mid_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [mid_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  wire logic [mid_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mid_pkg::*;

   typedef logic [AXES-1:0][SAMPLE_BITS-1:0] sample_vec_type;

   // configuration registers
   logic [EPS_W-1:0]   epsilon_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // input register (skid side)
   logic           in_valid_ff;
   logic           in_valid_in;
   logic           in_data_ready_ff;
   logic           in_motion_wake_ff;
   sample_vec_type in_smp_ff;
   sample_vec_type req_smp;

   // stored reference sample
   sample_vec_type prev_smp_ff;

   // result register
   logic           out_valid_ff;
   logic           out_valid_in;
   event_type      out_event_ff;
   sample_vec_type out_smp_ff;

   logic               req_fire;
   logic               advance;
   logic [SENSORS-1:0] sensor_still;
   logic               all_still;
   decision_type       decision;
   ctrl_status_type    status;

   // ---------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EPS_RESET;
         limit_ff   <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_STILL_EPSILON: epsilon_ff <= csr_wdata[EPS_W-1:0];
            CSR_STILL_LIMIT:   limit_ff   <= csr_wdata[LIMIT_W-1:0];
            default:           ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // handshake: input reg drains into result reg when it is free or being read
   // ---------------------------------------------------------------
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // axis order: accel xyz, gyro xyz, mag xyz
   always_comb begin
      req_smp[0] = req_ch.accel_x;
      req_smp[1] = req_ch.accel_y;
      req_smp[2] = req_ch.accel_z;
      req_smp[3] = req_ch.gyro_x;
      req_smp[4] = req_ch.gyro_y;
      req_smp[5] = req_ch.gyro_z;
      req_smp[6] = req_ch.mag_x;
      req_smp[7] = req_ch.mag_y;
      req_smp[8] = req_ch.mag_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ready_ff  <= req_ch.data_ready;
         in_motion_wake_ff <= req_ch.motion_wake;
         in_smp_ff         <= req_smp;
      end
   end

   // ---------------------------------------------------------------
   // stillness check, one unit per sensor against the stored sample
   // ---------------------------------------------------------------
   for (genvar g = 0; g < SENSORS; g++) begin : g_sensor
      mid_sensor_still #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_still (
         .now_smp (in_smp_ff[g*AXES_PER_SENSOR +: AXES_PER_SENSOR]),
         .old_smp (prev_smp_ff[g*AXES_PER_SENSOR +: AXES_PER_SENSOR]),
         .epsilon (epsilon_ff),
         .still   (sensor_still[g])
      );
   end

   assign all_still = &sensor_still;

   // ---------------------------------------------------------------
   // sleep / active control and still counter
   // ---------------------------------------------------------------
   mid_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .data_ready  (in_data_ready_ff),
      .motion_wake (in_motion_wake_ff),
      .all_still   (all_still),
      .still_limit (limit_ff),
      .decision    (decision),
      .status      (status)
   );

   // reference sample; a sample that puts the block to sleep is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_smp_ff <= '0;
      end else if (advance && decision.store) begin
         prev_smp_ff <= in_smp_ff;
      end
   end

   // ---------------------------------------------------------------
   // result register; sample fields read zero unless a sample is forwarded
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_event_ff <= decision.ev;
         out_smp_ff   <= (decision.ev == EV_FORWARD) ? in_smp_ff : '0;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.event_res   = out_event_ff;
   assign rsp_ch.out_accel_x = out_smp_ff[0];
   assign rsp_ch.out_accel_y = out_smp_ff[1];
   assign rsp_ch.out_accel_z = out_smp_ff[2];
   assign rsp_ch.out_gyro_x  = out_smp_ff[3];
   assign rsp_ch.out_gyro_y  = out_smp_ff[4];
   assign rsp_ch.out_gyro_z  = out_smp_ff[5];
   assign rsp_ch.out_mag_x   = out_smp_ff[6];
   assign rsp_ch.out_mag_y   = out_smp_ff[7];
   assign rsp_ch.out_mag_z   = out_smp_ff[8];

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   // the counter is always cleared on the way into sleep and held there
   `MID_ASSERT_SAME(a_sleep_count_zero, clock, reset,
      status.state == ST_SLEEP, status.still_count == '0,
      "still count nonzero while asleep")

   // a sleep decision leaves the block asleep
   `MID_ASSERT_NEXT(a_sleep_takes_effect, clock, reset,
      advance && decision.ev == EV_SLEEP, status.state == ST_SLEEP,
      "sleep decision did not put the block to sleep")

   // a wake decision leaves the block active
   `MID_ASSERT_NEXT(a_wake_takes_effect, clock, reset,
      advance && decision.ev == EV_WAKE, status.state == ST_ACTIVE,
      "wake decision did not wake the block")

   // samples only ride along with a forwarded word
   `MID_ASSERT_SAME(a_zero_unless_forward, clock, reset,
      out_valid_ff && out_event_ff != EV_FORWARD, out_smp_ff == '0,
      "sample fields nonzero on a non-forward word")

endmodule

`default_nettype wire

// File: rtl/mid_sensor_still.sv
`default_nettype none

module mid_sensor_still #(
   parameter int SAMPLE_BITS = mid_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic [mid_pkg::AXES_PER_SENSOR-1:0][SAMPLE_BITS-1:0] now_smp,
   input  wire logic [mid_pkg::AXES_PER_SENSOR-1:0][SAMPLE_BITS-1:0] old_smp,
   input  wire logic [mid_pkg::EPS_W-1:0]                            epsilon,
   output logic                                                      still
);
   import mid_pkg::*;

   // three differences of SAMPLE_BITS+1 bits summed need two more bits
   localparam int SUM_W = SAMPLE_BITS + 3;
   localparam int CMP_W = (SUM_W > EPS_W) ? SUM_W : EPS_W;

   logic signed [SUM_W-1:0] sum;
   logic        [SUM_W-1:0] mag;

   always_comb begin
      sum = '0;
      for (int i = 0; i < AXES_PER_SENSOR; i++) begin
         sum = sum + SUM_W'($signed(now_smp[i])) - SUM_W'($signed(old_smp[i]));
      end
      mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      still = (CMP_W'(mag) <= CMP_W'(epsilon));
   end

endmodule

`default_nettype wire

// File: rtl/mid_ctrl.sv
`default_nettype none

module mid_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          data_ready,
   input  wire logic                          motion_wake,
   input  wire logic                          all_still,
   input  wire logic [mid_pkg::LIMIT_W-1:0]   still_limit,
   output mid_pkg::decision_type              decision,
   output mid_pkg::ctrl_status_type           status
);
   import mid_pkg::*;

   state_type          state_ff;
   state_type          state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W:0]   count_inc;
   logic               limit_hit;

   // one extra bit so a count of 255 still reaches any limit
   assign count_inc = {1'b0, count_ff} + (COUNT_W + 1)'(1);
   assign limit_hit = (count_inc >= {1'b0, still_limit});

   // next state
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_SLEEP: begin
            if (motion_wake) begin
               state_in = ST_ACTIVE;
            end
         end
         ST_ACTIVE: begin
            if (data_ready) begin
               if (!all_still) begin
                  count_in = '0;
               end else if (limit_hit) begin
                  count_in = '0;
                  state_in = ST_SLEEP;
               end else begin
                  count_in = count_inc[COUNT_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_SLEEP;
         end
      endcase
   end

   // outputs
   always_comb begin
      decision.ev    = EV_NONE;
      decision.store = 1'b0;
      case (state_ff)
         ST_SLEEP: begin
            if (motion_wake) begin
               decision.ev = EV_WAKE;
            end
         end
         ST_ACTIVE: begin
            if (data_ready) begin
               if (all_still && limit_hit) begin
                  decision.ev = EV_SLEEP;
               end else begin
                  decision.ev    = EV_FORWARD;
                  decision.store = 1'b1;
               end
            end
         end
         default: begin
            decision.ev = EV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SLEEP;
         count_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign status.state       = state_ff;
   assign status.still_count = count_ff;

endmodule

`default_nettype wire

// File: tb/motion_inactivity_detector_tb.sv
`timescale 1ns / 100ps

module motion_inactivity_detector_tb;
   import mid_pkg::*;

   localparam int SB             = SAMPLE_BITS_DEFAULT;
   localparam int AXIS_MAX       = 2 ** (SB - 1) - 1;
   localparam int AXIS_MIN       = -(2 ** (SB - 1));
   localparam int EPS_MAX        = 2 ** EPS_W - 1;
   localparam int TIMEOUT_CYCLES = 400000;
   // two register stages inside the block, plus margin
   localparam int DRAIN_CYCLES   = 10;

   typedef logic signed [SB-1:0] axis_type;

   // one request word: flags plus nine axes (accel xyz, gyro xyz, mag xyz)
   typedef struct packed {
      logic                data_ready;
      logic                motion_wake;
      axis_type [AXES-1:0] smp;
   } sensor_word_type;

   // one expected response word
   typedef struct packed {
      event_type           ev;
      axis_type [AXES-1:0] smp;
   } report_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_idx_type           csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mid_req_if #(.SAMPLE_BITS(SB)) req_if ();
   mid_rsp_if #(.SAMPLE_BITS(SB)) rsp_if ();

   motion_inactivity_detector #(.SAMPLE_BITS(SB)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the detector state and its registers
   state_type           mirror_state;
   logic [COUNT_W-1:0]  mirror_count;
   axis_type [AXES-1:0] mirror_stored;
   logic [EPS_W-1:0]    mirror_eps;
   logic [LIMIT_W-1:0]  mirror_limit;

   report_type  pending_reports[$];
   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;
   bit          src_idle_en;
   bit          snk_stall_en;

   string axis_label [AXES] = '{"accel_x", "accel_y", "accel_z",
                                "gyro_x", "gyro_y", "gyro_z",
                                "mag_x", "mag_y", "mag_z"};

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run limit
   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // response back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_if.ready <= !snk_stall_en || ($urandom_range(0, 99) >= 24);
   end

   // expected response for one accepted word; advances the shadow state
   function automatic report_type next_report(input sensor_word_type w);
      report_type r;
      logic       still;
      int         sum;
      int         nxt;
      r    = '0;
      r.ev = EV_NONE;
      if (mirror_state == ST_SLEEP) begin
         // asleep: only the wake flag matters, samples are ignored
         if (w.motion_wake) begin
            mirror_state = ST_ACTIVE;
            r.ev         = EV_WAKE;
         end
      end else if (w.data_ready) begin
         still = 1'b1;
         for (int j = 0; j < SENSORS; j++) begin
            // signed sum of the three axis differences, exact in 32 bits
            sum = 0;
            for (int k = 0; k < AXES_PER_SENSOR; k++) begin
               sum += int'($signed(w.smp[3*j+k])) - int'($signed(mirror_stored[3*j+k]));
            end
            if (sum < 0) sum = -sum;
            if (sum > int'(mirror_eps)) still = 1'b0;
         end
         if (still) begin
            // "at least" compare, so a limit of zero or a lowered limit sleeps at once
            nxt = int'(mirror_count) + 1;
            if (nxt >= int'(mirror_limit)) begin
               mirror_count = '0;
               mirror_state = ST_SLEEP;
               r.ev         = EV_SLEEP;
            end else begin
               mirror_count = COUNT_W'(nxt);
            end
         end else begin
            mirror_count = '0;
         end
         // a word that puts the block to sleep is dropped, not stored
         if (r.ev != EV_SLEEP) begin
            r.ev          = EV_FORWARD;
            r.smp         = w.smp;
            mirror_stored = w.smp;
         end
      end
      return r;
   endfunction

   // accept monitor and response checker in one process, so a word accepted
   // at an edge is queued before any response at that edge is checked
   report_type          exp_r;
   logic [1:0]          got_ev;
   axis_type [AXES-1:0] got_smp;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            pending_reports.push_back(next_report('{req_if.data_ready, req_if.motion_wake,
               {req_if.mag_z, req_if.mag_y, req_if.mag_x,
                req_if.gyro_z, req_if.gyro_y, req_if.gyro_x,
                req_if.accel_z, req_if.accel_y, req_if.accel_x}}));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got_ev  = rsp_if.event_res;
            got_smp = {rsp_if.out_mag_z, rsp_if.out_mag_y, rsp_if.out_mag_x,
                       rsp_if.out_gyro_z, rsp_if.out_gyro_y, rsp_if.out_gyro_x,
                       rsp_if.out_accel_z, rsp_if.out_accel_y, rsp_if.out_accel_x};
            if (pending_reports.size() == 0) begin
               $error("response word with no request outstanding: event_res %0d", got_ev);
               fail_count++;
            end else begin
               exp_r = pending_reports.pop_front();
               if (got_ev !== exp_r.ev) begin
                  $error("event_res: expected %0d, got %0d", exp_r.ev, got_ev);
                  fail_count++;
               end
               for (int i = 0; i < AXES; i++) begin
                  if (got_smp[i] !== exp_r.smp[i]) begin
                     $error("out_%s: expected %0d, got %0d", axis_label[i],
                            $signed(exp_r.smp[i]), $signed(got_smp[i]));
                     fail_count++;
                  end
               end
            end
         end
      end
   end

   // request payload, nonblocking so it lands after the falling edge
   task automatic put_fields(input sensor_word_type w);
      req_if.data_ready  <= w.data_ready;
      req_if.motion_wake <= w.motion_wake;
      req_if.accel_x     <= w.smp[0];
      req_if.accel_y     <= w.smp[1];
      req_if.accel_z     <= w.smp[2];
      req_if.gyro_x      <= w.smp[3];
      req_if.gyro_y      <= w.smp[4];
      req_if.gyro_z      <= w.smp[5];
      req_if.mag_x       <= w.smp[6];
      req_if.mag_y       <= w.smp[7];
      req_if.mag_z       <= w.smp[8];
   endtask

   // offer one word, with random gaps, and return on the falling edge after accept;
   // valid is left high so back-to-back words need no second assignment
   task automatic send_word(input sensor_word_type w);
      while (src_idle_en && $urandom_range(0, 99) < 24) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      put_fields(w);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // wait for all responses, then write both registers while the block is idle
   task automatic configure(input logic [CSR_DATA_W-1:0] eps,
                            input logic [CSR_DATA_W-1:0] limit_word);
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= CSR_STILL_EPSILON;
      csr_wdata <= eps;
      @(negedge clock);
      mirror_eps = eps[EPS_W-1:0];
      csr_idx   <= CSR_STILL_LIMIT;
      csr_wdata <= limit_word;
      @(negedge clock);
      // only the low byte of the write data reaches the limit
      mirror_limit = limit_word[LIMIT_W-1:0];
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic sensor_word_type with_flags(input sensor_word_type w, input bit dr,
                                                  input bit mw);
      sensor_word_type r;
      r             = w;
      r.data_ready  = dr;
      r.motion_wake = mw;
      return r;
   endfunction

   function automatic sensor_word_type random_word();
      sensor_word_type w;
      w = '0;
      for (int i = 0; i < AXES; i++) w.smp[i] = axis_type'($urandom());
      w.data_ready  = $urandom_range(0, 1);
      w.motion_wake = $urandom_range(0, 1);
      return w;
   endfunction

   function automatic sensor_word_type fill_word(input axis_type v);
      sensor_word_type w;
      w = '0;
      for (int i = 0; i < AXES; i++) w.smp[i] = v;
      return w;
   endfunction

   function automatic int rand_signed(input int mag_max);
      int m;
      m = $urandom_range(0, mag_max);
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   // move axes lo..hi by a total of amount without wrapping; returns what was applied
   function automatic int shift_axes(inout sensor_word_type w, input int lo, input int hi,
                                     input int amount);
      int left;
      int v;
      int room;
      int step;
      left = amount;
      for (int i = lo; i <= hi; i++) begin
         v    = int'($signed(w.smp[i]));
         room = (left >= 0) ? AXIS_MAX - v : AXIS_MIN - v;
         if (left >= 0) step = (left < room) ? left : room;
         else step = (left > room) ? left : room;
         w.smp[i] = axis_type'(v + step);
         left -= step;
      end
      return amount - left;
   endfunction

   // data-ready word whose per-sensor summed difference to the stored word is
   // d_acc / d_gyr / d_mag; jitter adds cancelling motion between axes
   function automatic sensor_word_type offset_word(input int d_acc, input int d_gyr,
                                                   input int d_mag, input bit jitter);
      sensor_word_type w;
      int              d [SENSORS];
      int              t;
      w     = '0;
      w.smp = mirror_stored;
      d     = '{d_acc, d_gyr, d_mag};
      for (int j = 0; j < SENSORS; j++) begin
         if (jitter) begin
            t = shift_axes(w, 3*j, 3*j, rand_signed(400));
            void'(shift_axes(w, 3*j+1, 3*j+2, -t));
         end
         void'(shift_axes(w, 3*j, 3*j+2, d[j]));
      end
      w.data_ready = 1'b1;
      return w;
   endfunction

   // flag combinations in both states; samples ignored while waking
   task automatic test_flag_handling();
      send_word(with_flags(random_word(), 1'b1, 1'b0));
      send_word(with_flags(random_word(), 1'b0, 1'b0));
      send_word(with_flags(random_word(), 1'b1, 1'b1));
      send_word(with_flags(random_word(), 1'b0, 1'b1));
      send_word(with_flags(random_word(), 1'b1, 1'b1));
      send_word(with_flags(offset_word(0, 0, 0, 1'b0), 1'b1, 1'b1));
   endtask

   // sample extremes and alternating bit patterns on every axis
   task automatic test_sample_extremes();
      sensor_word_type w;
      send_word(with_flags(fill_word(axis_type'(AXIS_MAX)), 1'b1, 1'b0));
      send_word(with_flags(fill_word(axis_type'(AXIS_MIN)), 1'b1, 1'b0));
      w = fill_word(axis_type'(16'h5555));
      for (int i = 1; i < AXES; i += 2) w.smp[i] = axis_type'(16'hAAAA);
      send_word(with_flags(w, 1'b1, 1'b0));
      send_word(with_flags(fill_word('0), 1'b1, 1'b0));
   endtask

   // zero limit, masked limit write and a limit lowered below the count
   task automatic test_limit_cases();
      configure('0, '0);
      send_word(offset_word(0, 0, 0, 1'b0));
      send_word(with_flags(random_word(), 1'b0, 1'b1));
      send_word(offset_word(0, 0, 0, 1'b1));
      send_word(with_flags(random_word(), 1'b0, 1'b1));
      // widest epsilon: every word is still
      configure(CSR_DATA_W'(EPS_MAX), {10'h3FF, 8'd20});
      repeat (6) send_word(with_flags(random_word(), 1'b1, 1'b0));
      configure(CSR_DATA_W'(EPS_MAX), CSR_DATA_W'(4));
      send_word(with_flags(random_word(), 1'b1, 1'b0));
      send_word(with_flags(random_word(), 1'b0, 1'b1));
   endtask

   // summed difference right at epsilon and one above, up to the full swing
   task automatic test_epsilon_boundary();
      configure(CSR_DATA_W'(5), CSR_DATA_W'(50));
      send_word(offset_word(5, -5, 0, 1'b1));
      send_word(offset_word(6, 0, 0, 1'b1));
      send_word(offset_word(0, 0, -5, 1'b1));
      configure(CSR_DATA_W'(196605), CSR_DATA_W'(50));
      send_word(with_flags(fill_word(axis_type'(AXIS_MIN)), 1'b1, 1'b0));
      send_word(with_flags(fill_word(axis_type'(AXIS_MAX)), 1'b1, 1'b0));
      configure(CSR_DATA_W'(196604), CSR_DATA_W'(50));
      send_word(with_flags(fill_word(axis_type'(AXIS_MIN)), 1'b1, 1'b0));
   endtask

   // phases of random traffic, each with its own register setting; most words
   // are wake events while asleep and near-still samples while awake
   task automatic test_random_traffic();
      sensor_word_type w;
      int              eps;
      int              lim;
      int              still_pct;
      int              n_words;
      int              useful;
      int              cap;
      int              d [SENSORS];
      int              sel;
      for (int p = 0; p < 11; p++) begin
         n_words      = 80;
         src_idle_en  = 1'b1;
         snk_stall_en = 1'b1;
         case (p)
            0: begin
               eps = 10; lim = 50; still_pct = 85;
            end
            1: begin
               eps = 0; lim = 1; still_pct = 70;
            end
            2: begin
               // long stretch with no gaps and no stalls, two full count-ups
               eps = EPS_MAX; lim = 255; still_pct = 100; n_words = 520;
               src_idle_en  = 1'b0;
               snk_stall_en = 1'b0;
            end
            3: begin
               eps = 196605; lim = 0; still_pct = 50;
            end
            4: begin
               eps = 1; lim = 2; still_pct = 60;
            end
            default: begin
               eps = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, EPS_MAX);
               lim = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 12);
               still_pct = $urandom_range(50, 95);
            end
         endcase
         configure(CSR_DATA_W'(eps), CSR_DATA_W'(lim));
         useful = 0;
         while (useful < n_words) begin
            if (mirror_state == ST_SLEEP) begin
               w = random_word();
               w.motion_wake = ($urandom_range(0, 99) < 75);
               if (w.motion_wake) useful++;
            end else begin
               if ($urandom_range(0, 99) < still_pct) begin
                  cap = (eps > 60000) ? 60000 : eps;
                  for (int j = 0; j < SENSORS; j++) d[j] = rand_signed(cap);
                  // now and then one sensor sits on the epsilon edge or just past it
                  sel = $urandom_range(0, 9);
                  if (sel < SENSORS) begin
                     d[sel] = $urandom_range(0, 1) ? eps : eps + 1;
                     if ($urandom_range(0, 1)) d[sel] = -d[sel];
                  end
                  w = offset_word(d[0], d[1], d[2], 1'b1);
               end else begin
                  w = random_word();
               end
               w.data_ready  = ($urandom_range(0, 99) < 90);
               w.motion_wake = $urandom_range(0, 1);
               if (w.data_ready) useful++;
            end
            send_word(w);
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_idx      = CSR_STILL_EPSILON;
      csr_wdata    = '0;
      req_if.valid = 1'b0;
      rsp_if.ready = 1'b0;
      src_idle_en  = 1'b1;
      snk_stall_en = 1'b1;
      put_fields('0);
      // shadow state after reset
      mirror_state  = ST_SLEEP;
      mirror_count  = '0;
      mirror_stored = '0;
      mirror_eps    = EPS_RESET;
      mirror_limit  = LIMIT_RESET;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_flag_handling();
      test_sample_extremes();
      test_limit_cases();
      test_epsilon_boundary();
      test_random_traffic();

      // drain, then let the pipeline settle
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
